// ----- src/bbd_pkg.sv -----
`timescale 1ns / 1ps
package bbd_pkg;

  // Width of the internal timestamp state; timestamps are taken modulo 2^TIME_BITS.
  localparam int TIME_BITS = 48;
  localparam int TS_W      = 48;
  localparam int SIZE_W    = 16;
  localparam int CNT_W     = 32;
  localparam int TOT_W     = 48;
  localparam int CPKT_W    = 5;
  localparam int CBYTE_W   = 20;
  localparam int GAP_W     = 48;
  localparam int THR_W     = 4;
  localparam int CFG_W     = 48;
  localparam int SUM_W     = ((TIME_BITS > TOT_W) ? TIME_BITS : TOT_W) + 1;

  // Configuration register indices.
  localparam logic CfgBulkGap = 1'b0;
  localparam logic CfgMinPkts = 1'b1;

  localparam logic [GAP_W-1:0] GapReset = GAP_W'(1000000);
  localparam logic [THR_W-1:0] MinPktsReset = THR_W'(4);
  localparam logic [THR_W-1:0] MinThr = THR_W'(2);

  typedef logic [TIME_BITS-1:0] time_t;

  typedef struct packed {
    logic [GAP_W-1:0] gap;
    logic [THR_W-1:0] min_pkts;
  } bbd_cfg_t;

  // Packed so that count sits in the lowest bits.
  typedef struct packed {
    logic [TOT_W-1:0] dur;
    logic [TOT_W-1:0] bytes;
    logic [CNT_W-1:0] packets;
    logic [CNT_W-1:0] count;
  } bbd_totals_t;

endpackage

// ----- src/bbd_lane.sv -----
`timescale 1ns / 1ps
module bbd_lane (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  bbd_pkg::time_t            ts_i,
  input  logic [bbd_pkg::SIZE_W-1:0] size_i,
  input  bbd_pkg::time_t            other_last_i,
  input  bbd_pkg::bbd_cfg_t         cfg_i,
  output bbd_pkg::time_t            last_o,
  output bbd_pkg::bbd_totals_t      totals_o
);
  import bbd_pkg::*;

  time_t              start_q, start_d;
  time_t              last_q, last_d;
  logic [CPKT_W-1:0]  pkts_q, pkts_d;
  logic [CBYTE_W-1:0] bytes_q, bytes_d;
  bbd_totals_t        tot_q, tot_d;

  time_t              start_c;
  time_t              span_last;
  time_t              span_start;
  time_t              span_sel;
  logic [THR_W-1:0]   thr;
  logic               restart;
  logic [CPKT_W:0]    pkts_sum;
  logic [CBYTE_W:0]   bytes_sum;
  logic [CPKT_W-1:0]  pkts_n;
  logic [CBYTE_W-1:0] bytes_n;
  logic [CNT_W:0]     cnt_sum;
  logic [CNT_W:0]     ptot_sum;
  logic [SUM_W-1:0]   btot_sum;
  logic [SUM_W-1:0]   dtot_sum;
  logic               commit;
  logic               extend;

  localparam logic [SUM_W-1:0] TotMax = SUM_W'({TOT_W{1'b1}});
  localparam logic [CNT_W:0]   CntMax = {1'b0, {CNT_W{1'b1}}};

  always_comb begin
    // A later payload packet in the other direction cancels this candidate.
    start_c    = (other_last_i > start_q) ? '0 : start_q;
    span_last  = (ts_i >= last_q) ? (ts_i - last_q) : '0;
    span_start = (ts_i >= start_c) ? (ts_i - start_c) : '0;
    thr        = (cfg_i.min_pkts < MinThr) ? MinThr : cfg_i.min_pkts;
    restart    = (start_c == '0) || (SUM_W'(span_last) > SUM_W'(cfg_i.gap));

    pkts_sum  = {1'b0, pkts_q} + (CPKT_W+1)'(1);
    pkts_n    = pkts_sum[CPKT_W] ? '1 : pkts_sum[CPKT_W-1:0];
    bytes_sum = {1'b0, bytes_q} + (CBYTE_W+1)'(size_i);
    bytes_n   = bytes_sum[CBYTE_W] ? '1 : bytes_sum[CBYTE_W-1:0];

    commit = (pkts_n == CPKT_W'(thr));
    extend = (pkts_n > CPKT_W'(thr));

    span_sel = commit ? span_start : span_last;
    cnt_sum  = {1'b0, tot_q.count} + (CNT_W+1)'(1);
    ptot_sum = {1'b0, tot_q.packets} + (commit ? (CNT_W+1)'(pkts_n) : (CNT_W+1)'(1));
    btot_sum = SUM_W'(tot_q.bytes) + (commit ? SUM_W'(bytes_n) : SUM_W'(size_i));
    dtot_sum = SUM_W'(tot_q.dur) + SUM_W'(span_sel);

    start_d = start_q;
    last_d  = last_q;
    pkts_d  = pkts_q;
    bytes_d = bytes_q;
    tot_d   = tot_q;

    if (step_i) begin
      start_d = start_c;
      if (size_i != '0) begin
        if (restart) begin
          start_d = ts_i;
          last_d  = ts_i;
          pkts_d  = CPKT_W'(1);
          bytes_d = CBYTE_W'(size_i);
        end else begin
          pkts_d  = pkts_n;
          bytes_d = bytes_n;
          last_d  = ts_i;
          if (commit || extend) begin
            if (commit) begin
              tot_d.count = (cnt_sum > CntMax) ? '1 : cnt_sum[CNT_W-1:0];
            end
            tot_d.packets = (ptot_sum > CntMax) ? '1 : ptot_sum[CNT_W-1:0];
            tot_d.bytes   = (btot_sum > TotMax) ? '1 : btot_sum[TOT_W-1:0];
            tot_d.dur     = (dtot_sum > TotMax) ? '1 : dtot_sum[TOT_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      last_q  <= '0;
      pkts_q  <= '0;
      bytes_q <= '0;
      tot_q   <= '0;
    end else begin
      start_q <= start_d;
      last_q  <= last_d;
      pkts_q  <= pkts_d;
      bytes_q <= bytes_d;
      tot_q   <= tot_d;
    end
  end

  assign last_o   = last_q;
  assign totals_o = tot_q;

endmodule

// ----- src/bidirectional_bulk_detector.sv -----
`timescale 1ns / 1ps
// An input transaction reaches the master side through the input register, then
// the per-direction state, which is also the result register.
// Throughput: one packet per cycle unless the master side stalls; the state update
// for a packet is finished as it leaves the input register, so the next follows without a bubble.
// Reset clears all candidates and totals and loads the register reset values.
module bidirectional_bulk_detector (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // timestamp [47:0], payload_length [63:48]
  input  logic [63:0]               s_axis_tdata,
  // is_forward [0]
  input  logic                      s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // fwd_bulk_count, fwd_bulk_packets, fwd_bulk_bytes, fwd_bulk_time,
  // bwd_bulk_count, bwd_bulk_packets, bwd_bulk_bytes, bwd_bulk_time
  output logic [319:0]              m_axis_tdata,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [bbd_pkg::CFG_W-1:0] cfg_wdata_i
);
  import bbd_pkg::*;

  bbd_cfg_t          cfg_q;
  logic              in_valid_q;
  logic              in_fwd_q;
  logic [TS_W-1:0]   in_ts_q;
  logic [SIZE_W-1:0] in_size_q;
  logic              out_valid_q, out_valid_d;
  logic              advance;
  time_t             ts_c;
  time_t             fwd_last, bwd_last;
  bbd_totals_t       fwd_tot, bwd_tot;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign ts_c          = TIME_BITS'(in_ts_q);

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gap      <= GapReset;
      cfg_q.min_pkts <= MinPktsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgBulkGap: cfg_q.gap      <= cfg_wdata_i[GAP_W-1:0];
        CfgMinPkts: cfg_q.min_pkts <= cfg_wdata_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_fwd_q  <= s_axis_tuser;
      in_ts_q   <= s_axis_tdata[TS_W-1:0];
      in_size_q <= s_axis_tdata[TS_W+SIZE_W-1:TS_W];
    end
  end

  bbd_lane u_fwd (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance && in_fwd_q),
    .ts_i        (ts_c),
    .size_i      (in_size_q),
    .other_last_i(bwd_last),
    .cfg_i       (cfg_q),
    .last_o      (fwd_last),
    .totals_o    (fwd_tot)
  );

  bbd_lane u_bwd (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance && !in_fwd_q),
    .ts_i        (ts_c),
    .size_i      (in_size_q),
    .other_last_i(fwd_last),
    .cfg_i       (cfg_q),
    .last_o      (bwd_last),
    .totals_o    (bwd_tot)
  );

  // The totals registers are only updated when a result is launched, so they
  // serve directly as the result register.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {bwd_tot, fwd_tot};

`ifndef SYNTHESIS
  a_fwd_count_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (fwd_tot.count >= $past(fwd_tot.count)))
    else $error("forward bulk count decreased");

  a_bwd_count_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (bwd_tot.count >= $past(bwd_tot.count)))
    else $error("backward bulk count decreased");

  a_totals_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(fwd_tot) && $stable(bwd_tot)))
    else $error("totals changed without a packet being processed");
`endif

endmodule

// ----- tb/bidirectional_bulk_detector_test.sv -----
`timescale 1ns / 1ps
module bidirectional_bulk_detector_test;
  import bbd_pkg::*;

  localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;
  localparam int ItemsPerPhase = 200;
  localparam int NumPhases = 8;
  localparam int DirectedRows = 22;

  // Index 0 holds the forward totals, index 1 the backward ones.
  typedef bbd_totals_t [1:0] flow_totals_t;

  typedef struct {
    logic [47:0] start;
    logic [47:0] last;
    logic [4:0]  pkts;
    logic [19:0] bytes;
    logic [31:0] num;
    logic [31:0] pkt_total;
    logic [47:0] byte_total;
    logic [47:0] time_total;
  } dir_state_t;

  typedef struct {
    logic         fwd;
    logic [47:0]  ts;
    logic [15:0]  len;
    bit           typed;
    flow_totals_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [319:0] m_axis_tdata;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  dir_state_t   flow_dir [2];
  logic [47:0]  gap_q;
  logic [3:0]   min_pkts_q;
  flow_totals_t pending_totals [$];
  int           mismatch_count = 0;
  bit           allow_idle = 1'b1;
  int           stall_left = 0;

  // Directed packets at the reset configuration: no-candidate start at time zero,
  // no payload, commit, time going backward, cancellation, gap restart, wrap.
  stim_row_t directed_rows [DirectedRows] = '{
    '{1'b1, 48'd0,       16'd100,   1'b1, '0},
    '{1'b1, 48'd10,      16'd100,   1'b1, '0},
    '{1'b1, 48'd20,      16'd0,     1'b1, '0},
    '{1'b1, 48'd30,      16'hFFFF,  1'b1, '0},
    '{1'b1, 48'd40,      16'd1,     1'b1, '0},
    '{1'b1, 48'd50,      16'd200,   1'b0, '0},
    '{1'b1, 48'd45,      16'd10,    1'b0, '0},
    '{1'b1, 48'd1000045, 16'd7,     1'b0, '0},
    '{1'b0, 48'd1000050, 16'd5,     1'b0, '0},
    '{1'b1, 48'd1000060, 16'd5,     1'b0, '0},
    '{1'b0, 48'd1000070, 16'd0,     1'b0, '0},
    '{1'b0, 48'd1000080, 16'd9,     1'b0, '0},
    '{1'b1, 48'd1000090, 16'd5,     1'b0, '0},
    '{1'b1, 48'd1000100, 16'd5,     1'b0, '0},
    '{1'b1, 48'd2000101, 16'd5,     1'b0, '0},
    '{1'b1, 48'd2000102, 16'd5,     1'b0, '0},
    '{1'b1, 48'd2000103, 16'd5,     1'b0, '0},
    '{1'b1, 48'd2000104, 16'd5,     1'b0, '0},
    '{1'b1, Max48,       16'hFFFF,  1'b0, '0},
    '{1'b0, Max48,       16'hFFFF,  1'b0, '0},
    '{1'b0, 48'd0,       16'hFFFF,  1'b0, '0},
    '{1'b0, 48'd0,       16'd0,     1'b0, '0}
  };

  bidirectional_bulk_detector i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [63:0] clamp_add(logic [63:0] a, logic [63:0] b,
                                            logic [63:0] limit);
    if (a >= limit || b > limit - a) return limit;
    return a + b;
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  // Applies one packet to the bulk state and returns the totals it reports.
  function automatic flow_totals_t advance_flow(logic fwd, logic [47:0] ts,
                                                logic [15:0] len);
    int d;
    int o;
    logic [4:0] thr;
    flow_totals_t res;
    d = fwd ? 0 : 1;
    o = 1 - d;
    thr = (min_pkts_q < 4'd2) ? 5'd2 : {1'b0, min_pkts_q};
    if (flow_dir[o].last > flow_dir[d].start) flow_dir[d].start = '0;
    if (len != 16'd0) begin
      if (flow_dir[d].start == '0 ||
          (ts >= flow_dir[d].last && ts - flow_dir[d].last > gap_q)) begin
        flow_dir[d].start = ts;
        flow_dir[d].last  = ts;
        flow_dir[d].pkts  = 5'd1;
        flow_dir[d].bytes = {4'd0, len};
      end else begin
        flow_dir[d].pkts  = 5'(clamp_add(flow_dir[d].pkts, 1, 64'd31));
        flow_dir[d].bytes = 20'(clamp_add(flow_dir[d].bytes, len, 64'hF_FFFF));
        if (flow_dir[d].pkts == thr) begin
          flow_dir[d].num = 32'(clamp_add(flow_dir[d].num, 1, 64'hFFFF_FFFF));
          flow_dir[d].pkt_total = 32'(clamp_add(flow_dir[d].pkt_total,
                                                flow_dir[d].pkts, 64'hFFFF_FFFF));
          flow_dir[d].byte_total = 48'(clamp_add(flow_dir[d].byte_total,
                                                 flow_dir[d].bytes, Max48));
          flow_dir[d].time_total = 48'(clamp_add(flow_dir[d].time_total,
              (ts >= flow_dir[d].start) ? ts - flow_dir[d].start : 48'd0, Max48));
        end else if (flow_dir[d].pkts > thr) begin
          flow_dir[d].pkt_total = 32'(clamp_add(flow_dir[d].pkt_total, 1,
                                                64'hFFFF_FFFF));
          flow_dir[d].byte_total = 48'(clamp_add(flow_dir[d].byte_total, len, Max48));
          flow_dir[d].time_total = 48'(clamp_add(flow_dir[d].time_total,
              (ts >= flow_dir[d].last) ? ts - flow_dir[d].last : 48'd0, Max48));
        end
        flow_dir[d].last = ts;
      end
    end
    for (int k = 0; k < 2; k++) begin
      res[k].count   = flow_dir[k].num;
      res[k].packets = flow_dir[k].pkt_total;
      res[k].bytes   = flow_dir[k].byte_total;
      res[k].dur     = flow_dir[k].time_total;
    end
    return res;
  endfunction

  // Timestamp increment: mostly within the gap, sometimes beyond it, backward, or anywhere.
  function automatic logic [47:0] next_step(logic [47:0] gap);
    int r;
    logic [63:0] span_lim;
    r = $urandom_range(0, 99);
    if (r < 45) return 48'($urandom_range(0, (gap > 48'd1000) ? 1000 : int'(gap)));
    span_lim = {16'd0, gap} + 64'd1;
    if (r < 70) return 48'({16'd0, rand48()} % span_lim);
    if (r < 82) return gap + 48'd1 + 48'($urandom_range(0, 3));
    if (r < 92) return -48'($urandom_range(1, 100));
    return rand48();
  endfunction

  task automatic send_packet(input logic fwd, input logic [47:0] ts, input logic [15:0] len,
                             input bit typed, input flow_totals_t want);
    flow_totals_t predicted;
    flow_totals_t queued;
    if (allow_idle && $urandom_range(0, 99) < 10) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {len, ts};
    s_axis_tuser  <= fwd;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = advance_flow(fwd, ts, len);
    queued = typed ? want : predicted;
    pending_totals.insert(pending_totals.size(), queued);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_bulk_config(input logic [47:0] gap, input logic [3:0] min_pkts);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgBulkGap;
    cfg_wdata_i <= gap;
    @(posedge clk_i);
    cfg_idx_i   <= CfgMinPkts;
    cfg_wdata_i <= CFG_W'(min_pkts);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    gap_q      = gap;
    min_pkts_q = min_pkts;
  endtask

  initial begin
    logic [47:0] gap;
    logic [3:0]  min_pkts;
    logic [47:0] clock_ts;
    logic        dir;
    logic [15:0] len;
    int          sent;
    int          burst;
    int          r;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CfgBulkGap;
    cfg_wdata_i   <= '0;
    gap_q      = 48'd1000000;
    min_pkts_q = 4'd4;
    for (int k = 0; k < 2; k++) flow_dir[k] = '{default: '0};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_packet(directed_rows[i].fwd, directed_rows[i].ts, directed_rows[i].len,
                  directed_rows[i].typed, directed_rows[i].want);

    clock_ts = 48'd1;
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: begin gap = Max48; min_pkts = 4'd15; end
        1: begin gap = 48'd0; min_pkts = 4'd0; end
        2: begin gap = 48'd1000; min_pkts = 4'd1; end
        3: begin gap = 48'd50; min_pkts = 4'd2; end
        4: begin gap = rand48(); min_pkts = 4'($urandom_range(0, 15)); end
        5: begin gap = 48'd20; min_pkts = 4'd3; end
        6: begin gap = 48'($urandom_range(0, 100000)); min_pkts = 4'($urandom); end
        default: begin gap = 48'd1000000; min_pkts = 4'd4; end
      endcase
      set_bulk_config(gap, min_pkts);
      allow_idle = (phase != NumPhases - 1);
      sent = 0;
      // Bursts in one direction build candidates; stray packets the other way cancel them.
      while (sent < ItemsPerPhase) begin
        dir   = 1'($urandom);
        burst = $urandom_range(1, 48);
        for (int i = 0; i < burst && sent < ItemsPerPhase; i++) begin
          clock_ts = clock_ts + next_step(gap);
          r = $urandom_range(0, 99);
          len = (r < 10) ? 16'd0 : (r < 20) ? 16'hFFFF : (r < 25) ? 16'd1 : 16'($urandom);
          send_packet(($urandom_range(0, 99) < 8) ? !dir : dir, clock_ts, len, 1'b0, '0);
          sent++;
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (allow_idle && $urandom_range(0, 99) < 12) begin
        stall_left = $urandom_range(0, 11);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    flow_totals_t got;
    flow_totals_t want;
    logic [63:0] want_f [4];
    logic [63:0] got_f [4];
    string field_name [4];
    field_name = '{"count", "packets", "bytes", "time"};
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_totals.size() == 0) begin
        $display("%0t: result transaction with no packet outstanding", $time);
        mismatch_count++;
      end else begin
        want = pending_totals.pop_front();
        for (int k = 0; k < 2; k++) begin
          want_f = '{64'(want[k].count), 64'(want[k].packets), 64'(want[k].bytes),
                     64'(want[k].dur)};
          got_f  = '{64'(got[k].count), 64'(got[k].packets), 64'(got[k].bytes),
                     64'(got[k].dur)};
          for (int f = 0; f < 4; f++) begin
            if (want_f[f] !== got_f[f]) begin
              $display("%0t: %s bulk %s expected %0d, got %0d", $time,
                       (k == 0) ? "fwd" : "bwd", field_name[f], want_f[f], got_f[f]);
              mismatch_count++;
            end
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
